// ----- hdl/mlse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlse_pkg
// shared types and codes of the list store engine: operation and status
// codes, the result item and the compare unit's result group
// ----------------------------------------------------------------------------
package mlse_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 4;
   localparam int SIZE_W   = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 5;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CREATE,
      OP_APPEND,
      OP_DROP,
      OP_REMOVE,
      OP_RESIZE,
      OP_COUNT,
      OP_READ,
      OP_READ_SORTED
   } op_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 4'd0,
      ST_BAD_SLOT  = 4'd1,
      ST_NO_LIST   = 4'd2,
      ST_EXISTS    = 4'd3,
      ST_BAD_SIZE  = 4'd4,
      ST_NO_ROOM   = 4'd5,
      ST_FULL      = 4'd6,
      ST_EMPTY     = 4'd7,
      ST_NOT_FOUND = 4'd8
   } status_type;

   // one result item
   typedef struct packed {
      status_type          status;
      logic [COUNT_W-1:0]  count;
      logic                data_valid;
      logic [WORD_W-1:0]   data_value;
      logic                last;
   } rsp_item_type;

   // compare unit results: a against b, a against c
   typedef struct packed {
      logic eq_ab;
      logic lt_ab;
      logic lt_ac;
   } cmp_result_type;

endpackage
`default_nettype wire

// ----- hdl/mlse_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlse_cmp
// shared signed word compare unit, used by the remove scan and the
// sorted read selection
// ----------------------------------------------------------------------------
module mlse_cmp
   import mlse_pkg::*;
(
   input  logic signed [WORD_W-1:0] a,
   input  logic signed [WORD_W-1:0] b,
   input  logic signed [WORD_W-1:0] c,
   output cmp_result_type           res
);

   // equality and signed ordering
   assign res.eq_ab = (a == b);
   assign res.lt_ab = (a < b);
   assign res.lt_ac = (a < c);

endmodule
`default_nettype wire

// ----- hdl/mlse_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlse_ctrl
// list table, entry memory and the sequencer that walks one list at a time
// through the shared compare unit
// ----------------------------------------------------------------------------
module mlse_ctrl
   import mlse_pkg::*;
#(
   parameter int NUM_SLOTS = 10,
   parameter int CAPACITY  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  op_type                   req_op,
   input  logic [SLOT_W-1:0]        req_slot,
   input  logic signed [SIZE_W-1:0] req_size_arg,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     res_valid,
   input  logic                     res_ready,
   output rsp_item_type             res
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SWX   = (SW > SLOT_W) ? SW : SLOT_W;
   localparam int DEPTH = NUM_SLOTS * CAPACITY;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
   localparam int CXW   = (CW > COUNT_W) ? CW : COUNT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RESP,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_READ_RD,
      S_READ_CHK,
      S_SORT_RD,
      S_SORT_CHK
   } state_type;

   state_type                 state_ff;
   state_type                 ret_ff;
   op_type                    op_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic signed [SIZE_W-1:0]  size_ff;
   logic signed [WORD_W-1:0]  value_ff;
   logic                      exists_ff [NUM_SLOTS];
   logic [CW-1:0]             cap_ff [NUM_SLOTS];
   logic [CW-1:0]             cnt_ff [NUM_SLOTS];
   logic [CW-1:0]             pos_ff;
   logic [CW-1:0]             rank_ff;
   logic signed [WORD_W-1:0]  best_ff;
   logic [CW-1:0]             best_idx_ff;
   logic                      found_ff;
   logic signed [WORD_W-1:0]  prev_ff;
   logic [CW-1:0]             prev_idx_ff;
   rsp_item_type              res_ff;
   logic signed [WORD_W-1:0]  rdata_ff;
   logic [WORD_W-1:0]         store_ff [DEPTH];

   logic                      slot_ok;
   logic [SWX-1:0]            slot_x;
   logic [SW-1:0]             idx;
   logic                      cur_exists;
   logic [CW-1:0]             cur_cap;
   logic [CW-1:0]             cur_n;
   logic [CW-1:0]             n_inc;
   logic [CW-1:0]             n_dec;
   logic [AW-1:0]             base;
   logic signed [NW-1:0]      size_x;
   logic signed [NW-1:0]      newcap;
   logic [CW-1:0]             newcap_c;
   logic [CW-1:0]             clip_n;
   logic                      create_bad;
   logic                      create_big;
   logic                      resize_bad;
   logic                      resize_big;
   logic                      list_full;
   logic                      append_ok;
   logic                      walk_ok;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [WORD_W-1:0]         wr_data;
   cmp_result_type            cmp;
   logic signed [WORD_W-1:0]  cmp_b;
   logic                      after_prev;
   logic                      take;
   logic signed [WORD_W-1:0]  sel_v;
   logic [CW-1:0]             sel_i;

   // count of a list as the 5-bit result field
   function automatic logic [COUNT_W-1:0] to_cnt(input logic [CW-1:0] x);
      logic [CXW-1:0] t;
      t = CXW'(x);
      return t[COUNT_W-1:0];
   endfunction

   // status-only result
   function automatic rsp_item_type mk_res(input status_type st,
                                           input logic [CW-1:0] n);
      rsp_item_type r;
      r.status     = st;
      r.count      = to_cnt(n);
      r.data_valid = 1'b0;
      r.data_value = '0;
      r.last       = 1'b1;
      return r;
   endfunction

   // decode of the held request against the list table
   assign slot_ok    = (slot_ff != '0) && (int'(slot_ff) <= NUM_SLOTS);
   assign slot_x     = SWX'(slot_ff) - SWX'(1);
   assign idx        = slot_x[SW-1:0];
   assign cur_exists = exists_ff[idx];
   assign cur_cap    = cap_ff[idx];
   assign cur_n      = cnt_ff[idx];
   assign n_inc      = cur_n + CW'(1);
   assign n_dec      = cur_n - CW'(1);
   assign base       = AW'(idx) * AW'(CAPACITY);

   // capacity checks for create and resize
   assign size_x     = NW'(size_ff);
   assign newcap     = NW'(cur_cap) + size_x;
   assign newcap_c   = newcap[CW-1:0];
   assign clip_n     = (cur_n > newcap_c) ? newcap_c : cur_n;
   assign create_bad = size_ff[SIZE_W-1] || (size_ff == '0);
   assign create_big = (size_x > NW'(CAPACITY));
   assign resize_bad = newcap[NW-1] || (newcap == '0);
   assign resize_big = (newcap > NW'(CAPACITY));
   assign list_full  = (cur_n >= cur_cap) || (int'(cur_n) >= CAPACITY);
   assign append_ok  = (op_ff == OP_APPEND) && slot_ok && cur_exists && !list_full;
   assign walk_ok    = slot_ok && cur_exists && (cur_n != '0);

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = base + AW'(pos_ff);
      wr_en   = 1'b0;
      wr_addr = base + AW'(pos_ff);
      wr_data = rdata_ff;
      case (state_ff)
         S_SCAN_RD, S_READ_RD, S_SORT_RD: begin
            rd_en = 1'b1;
         end
         S_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(pos_ff) + AW'(1);
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         S_EXEC: begin
            wr_en   = append_ok;
            wr_addr = base + AW'(cur_n);
            wr_data = value_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   // shared compare unit
   assign cmp_b = (state_ff == S_SCAN_CHK) ? value_ff : prev_ff;

   mlse_cmp u_cmp (
      .a   (rdata_ff),
      .b   (cmp_b),
      .c   (best_ff),
      .res (cmp)
   );

   // sorted read: smallest (value, index) above the one last sent
   assign after_prev = (rank_ff == '0) || (!cmp.lt_ab && !cmp.eq_ab) ||
                       (cmp.eq_ab && (pos_ff > prev_idx_ff));
   assign take       = after_prev && (!found_ff || cmp.lt_ac);
   assign sel_v      = take ? rdata_ff : best_ff;
   assign sel_i      = take ? pos_ff : best_idx_ff;

   // sequencer and list table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            exists_ff[i] <= 1'b0;
            cap_ff[i]    <= '0;
            cnt_ff[i]    <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  slot_ff  <= req_slot;
                  size_ff  <= req_size_arg;
                  value_ff <= req_value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               pos_ff   <= '0;
               rank_ff  <= '0;
               found_ff <= 1'b0;
               ret_ff   <= S_IDLE;
               // walks over a non-empty list, everything else answers at once
               if (walk_ok && (op_ff == OP_REMOVE)) begin
                  state_ff <= S_SCAN_RD;
               end else if (walk_ok && (op_ff == OP_READ)) begin
                  state_ff <= S_READ_RD;
               end else if (walk_ok && (op_ff == OP_READ_SORTED)) begin
                  state_ff <= S_SORT_RD;
               end else begin
                  state_ff <= S_RESP;
               end
               if ((op_ff == OP_CREATE) && create_bad) begin
                  res_ff <= mk_res(ST_BAD_SIZE, '0);
               end else if (!slot_ok) begin
                  res_ff <= mk_res(ST_BAD_SLOT, '0);
               end else if (op_ff == OP_CREATE) begin
                  if (cur_exists) begin
                     res_ff <= mk_res(ST_EXISTS, cur_n);
                  end else if (create_big) begin
                     res_ff <= mk_res(ST_NO_ROOM, '0);
                  end else begin
                     exists_ff[idx] <= 1'b1;
                     cap_ff[idx]    <= size_x[CW-1:0];
                     cnt_ff[idx]    <= '0;
                     res_ff         <= mk_res(ST_OK, '0);
                  end
               end else if (!cur_exists) begin
                  res_ff <= mk_res(ST_NO_LIST, '0);
               end else begin
                  case (op_ff)
                     OP_APPEND: begin
                        if (list_full) begin
                           res_ff <= mk_res(ST_FULL, cur_n);
                        end else begin
                           cnt_ff[idx] <= n_inc;
                           res_ff      <= mk_res(ST_OK, n_inc);
                        end
                     end
                     OP_DROP: begin
                        if (cur_n == '0) begin
                           res_ff <= mk_res(ST_EMPTY, '0);
                        end else begin
                           cnt_ff[idx] <= n_dec;
                           res_ff      <= mk_res(ST_OK, n_dec);
                        end
                     end
                     OP_REMOVE: begin
                        if (cur_n == '0) begin
                           res_ff <= mk_res(ST_EMPTY, '0);
                        end
                     end
                     OP_RESIZE: begin
                        if (resize_bad) begin
                           res_ff <= mk_res(ST_BAD_SIZE, cur_n);
                        end else if (resize_big) begin
                           res_ff <= mk_res(ST_NO_ROOM, cur_n);
                        end else begin
                           cap_ff[idx] <= newcap_c;
                           cnt_ff[idx] <= clip_n;
                           res_ff      <= mk_res(ST_OK, clip_n);
                        end
                     end
                     OP_COUNT: begin
                        res_ff <= mk_res((cur_n == '0) ? ST_EMPTY : ST_OK, cur_n);
                     end
                     OP_READ, OP_READ_SORTED: begin
                        if (cur_n == '0) begin
                           res_ff <= mk_res(ST_OK, '0);
                        end
                     end
                     default: begin
                        res_ff <= mk_res(ST_OK, cur_n);
                     end
                  endcase
               end
            end
            S_RESP: begin
               if (res_ready) begin
                  state_ff <= ret_ff;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (cmp.eq_ab) begin
                  if (pos_ff == n_dec) begin
                     cnt_ff[idx] <= n_dec;
                     res_ff      <= mk_res(ST_OK, n_dec);
                     state_ff    <= S_RESP;
                  end else begin
                     state_ff <= S_SHIFT_RD;
                  end
               end else if (pos_ff == n_dec) begin
                  res_ff   <= mk_res(ST_NOT_FOUND, cur_n);
                  state_ff <= S_RESP;
               end else begin
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               if ((pos_ff + CW'(1)) == n_dec) begin
                  cnt_ff[idx] <= n_dec;
                  res_ff      <= mk_res(ST_OK, n_dec);
                  state_ff    <= S_RESP;
               end else begin
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_READ_RD: begin
               state_ff <= S_READ_CHK;
            end
            S_READ_CHK: begin
               res_ff.status     <= ST_OK;
               res_ff.count      <= to_cnt(cur_n);
               res_ff.data_valid <= 1'b1;
               res_ff.data_value <= rdata_ff;
               res_ff.last       <= (pos_ff == n_dec);
               ret_ff            <= (pos_ff == n_dec) ? S_IDLE : S_READ_RD;
               pos_ff            <= pos_ff + CW'(1);
               state_ff          <= S_RESP;
            end
            S_SORT_RD: begin
               state_ff <= S_SORT_CHK;
            end
            S_SORT_CHK: begin
               best_ff     <= sel_v;
               best_idx_ff <= sel_i;
               if (pos_ff == n_dec) begin
                  res_ff.status     <= ST_OK;
                  res_ff.count      <= to_cnt(cur_n);
                  res_ff.data_valid <= 1'b1;
                  res_ff.data_value <= sel_v;
                  res_ff.last       <= (rank_ff == n_dec);
                  ret_ff            <= (rank_ff == n_dec) ? S_IDLE : S_SORT_RD;
                  prev_ff           <= sel_v;
                  prev_idx_ff       <= sel_i;
                  rank_ff           <= rank_ff + CW'(1);
                  pos_ff            <= '0;
                  found_ff          <= 1'b0;
                  state_ff          <= S_RESP;
               end else begin
                  // a candidate is held only once one has been taken
                  found_ff <= found_ff || take;
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= S_SORT_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

`ifndef SYNTHESIS
   // a list never holds more entries than its capacity
   a_cnt_in_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && slot_ok && cur_exists) |-> (cur_n <= cur_cap))
      else $error("list count above capacity");

   // memory writes only land in an existing list
   a_wr_in_list: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (slot_ok && cur_exists))
      else $error("entry write outside an existing list");

   // the final result of an operation frees the block for the next request
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res.last) |=> req_ready)
      else $error("block not ready after final result");

   // data field is zero when it carries no entry
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res.data_valid || (res.data_value == '0)))
      else $error("data value set without an entry");
`endif

endmodule
`default_nettype wire

// ----- hdl/multi_list_store_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_list_store_engine
// bank of bounded signed-word lists with create, append, drop, remove,
// resize, count, read and sorted read requests
// ----------------------------------------------------------------------------
// One request is handled at a time; req_tready is low until its final result
// has moved into the output register. The entry memory has one read port with
// a registered read, so each entry visit has a read state followed by a check
// or write state. Create, append, drop, resize, count and failing requests are
// answered straight from the execute state; remove scans for the value and
// shifts the later entries down; read sends the entries in order; sorted read
// picks each next entry by a full pass over the list. Results stall in place while
// rsp_tready is low. No clearing pass is needed after reset.
module multi_list_store_engine
   import mlse_pkg::*;
#(
   parameter int NUM_SLOTS = 10,
   parameter int CAPACITY  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[2:0], slot[6:3], size_arg[12:7], value[44:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[3:0], count[8:4], data_value[40:9]
   output logic        rsp_tuser,   // data_valid
   output logic        rsp_tlast
);

   logic          res_valid;
   logic          res_ready;
   rsp_item_type  res;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   // sequencer with list table and entry memory
   mlse_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .CAPACITY  (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (op_type'(req_tdata[2:0])),
      .req_slot     (req_tdata[6:3]),
      .req_size_arg (req_tdata[12:7]),
      .req_value    (req_tdata[44:13]),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_item_ff <= res;
      end
   end

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_item_ff.data_value, rsp_item_ff.count,
                        rsp_item_ff.status};
   assign rsp_tuser  = rsp_item_ff.data_valid;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule
`default_nettype wire
